[src/gse_pkg.sv]
// Package: shared types, constants and GCR encode functions of the sector encoder.
`timescale 1ns / 1ps

package gse_pkg;

   localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
   localparam logic [7:0]  GAP_BYTE     = 8'h00;
   localparam logic [7:0]  HEADER_MARK  = 8'h08;
   localparam logic [7:0]  BLOCK_MARK   = 8'h07;
   localparam logic [7:0]  HEADER_PAD   = 8'h0F;
   localparam logic [7:0]  LAST_INDEX   = 8'hFF;
   localparam logic [7:0]  FIRST_INDEX  = 8'h00;
   localparam logic [1:0]  GROUP_PHASE  = 2'd2;
   localparam logic [39:0] ZERO_GROUP   = 40'h5294A5294A;

   localparam logic        REG_ID_FIRST  = 1'b0;
   localparam logic        REG_ID_SECOND = 1'b1;

   localparam logic [2:0]  HEAD_LAST_SEG  = 3'd5;
   localparam logic [2:0]  GROUP_LAST_SEG = 3'd0;
   localparam logic [2:0]  TAIL_LAST_SEG  = 3'd3;
   localparam logic [2:0]  LAST_SUB       = 3'd4;

   typedef enum logic [1:0] {
      JOB_HEAD  = 2'd0,
      JOB_GROUP = 2'd1,
      JOB_TAIL  = 2'd2
   } job_kind_type;

   typedef enum logic [1:0] {
      SEG_SYNC = 2'd0,
      SEG_GAP  = 2'd1,
      SEG_GRP  = 2'd2,
      SEG_ZERO = 2'd3
   } seg_kind_type;

   // head: {hsum, sector, track, id2, id1}; group: {b0,b1,b2,b3,pad}; tail: {d,csum,0,0,pad}
   typedef struct packed {
      job_kind_type kind;
      logic [39:0]  data;
   } job_type;

   function automatic logic [4:0] gcr_nibble(input logic [3:0] nib);
      logic [4:0] code;
      case (nib)
         4'h0: code = 5'h0a;
         4'h1: code = 5'h0b;
         4'h2: code = 5'h12;
         4'h3: code = 5'h13;
         4'h4: code = 5'h0e;
         4'h5: code = 5'h0f;
         4'h6: code = 5'h16;
         4'h7: code = 5'h17;
         4'h8: code = 5'h09;
         4'h9: code = 5'h19;
         4'ha: code = 5'h1a;
         4'hb: code = 5'h1b;
         4'hc: code = 5'h0d;
         4'hd: code = 5'h1d;
         4'he: code = 5'h1e;
         default: code = 5'h15;
      endcase
      return code;
   endfunction

   // four bytes, oldest in the high bits, to 40 GCR bits
   function automatic logic [39:0] gcr_group(input logic [31:0] word);
      logic [39:0] bits;
      bits = '0;
      for (int i = 0; i < 8; i++) begin
         bits[5*i +: 5] = gcr_nibble(word[4*i +: 4]);
      end
      return bits;
   endfunction

endpackage

[src/gcr_sector_encoder.sv]
// Top level of the GCR sector encoder: front end, job queue and byte sequencer.
`timescale 1ns / 1ps
//
// Usage: feed the 256 data bytes of a sector in order on the req_ channel,
// each with its track and sector number (sampled with the first byte only).
// The rsp_ channel returns the 370-byte GCR image one byte per transaction:
// the first byte of a sector yields 30 bytes (sync, header, gap, sync), every
// fourth byte from index 2 yields one 5-byte data group, and the last byte
// yields 20 bytes (final group, gap, trailer). rsp_run_last marks the last
// byte caused by a request; rsp_sector_done marks byte 370.
// The disk ID bytes are written over the APB-style port at offsets 0 and 4.
// The first response byte of a request passes through the job queue and the
// output register, behind any jobs already queued. The sequencer emits one
// byte per cycle while a job is queued and the receiver does not stall; the
// front end takes one request per cycle while the job queue has room.
// When the receiver stalls, the output register holds its byte and the job
// queue fills, after which req_stall rises. Reset clears the sector position,
// the checksum, the disk ID registers and the queue.
//
module gcr_sector_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_track_number,
   input  logic [7:0]  req_sector_number,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gcr_byte,
   output logic        rsp_run_last,
   output logic        rsp_sector_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   gse_pkg::job_type push_job;
   gse_pkg::job_type head_job;

   gse_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_track_number  (req_track_number),
      .req_sector_number (req_sector_number),
      .req_data_byte     (req_data_byte),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   gse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   gse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gcr_byte    (rsp_gcr_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_sector_done (rsp_sector_done)
   );

endmodule

[src/gse_queue.sv]
// Job queue between the classifying front end and the byte sequencer.
`timescale 1ns / 1ps

module gse_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gse_pkg::job_type push_job,
   input  logic             pop,
   output gse_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gse_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

[src/gse_front.sv]
// Front end: register port, sector position tracking, grouping and job classification.
`timescale 1ns / 1ps

module gse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_track_number,
   input  logic [7:0]       req_sector_number,
   input  logic [7:0]       req_data_byte,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   input  logic             queue_full,
   output logic             push,
   output gse_pkg::job_type push_job
);

   logic [7:0]  id_first_ff, id_first_in;
   logic [7:0]  id_second_ff, id_second_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [23:0] group_hold_ff, group_hold_in;
   logic [7:0]  checksum_ff, checksum_in;

   logic        take;
   logic        first;
   logic [7:0]  csum_new;
   logic [23:0] hold_base;
   logic [7:0]  hsum;
   logic        csr_write;

   assign pready    = 1'b1;
   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full;
   assign csr_write = psel && penable && pwrite;

   assign prdata = (paddr[2] == gse_pkg::REG_ID_SECOND) ? {24'd0, id_second_ff}
                                                         : {24'd0, id_first_ff};

   always_comb begin
      id_first_in  = id_first_ff;
      id_second_in = id_second_ff;
      if (csr_write) begin
         case (paddr[2])
            gse_pkg::REG_ID_FIRST:  id_first_in  = pwdata[7:0];
            gse_pkg::REG_ID_SECOND: id_second_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      first     = (byte_index_ff == gse_pkg::FIRST_INDEX);
      csum_new  = (first ? 8'd0 : checksum_ff) ^ req_data_byte;
      hold_base = first ? {16'd0, gse_pkg::BLOCK_MARK} : group_hold_ff;
      hsum      = req_sector_number ^ req_track_number ^ id_first_ff ^ id_second_ff;

      byte_index_in = byte_index_ff;
      group_hold_in = group_hold_ff;
      checksum_in   = checksum_ff;
      push          = 1'b0;
      push_job.kind = gse_pkg::JOB_GROUP;
      push_job.data = '0;

      if (take) begin
         byte_index_in = byte_index_ff + 8'd1;
         checksum_in   = csum_new;
         if (first) begin
            push          = 1'b1;
            push_job.kind = gse_pkg::JOB_HEAD;
            push_job.data = {hsum, req_sector_number, req_track_number,
                             id_second_ff, id_first_ff};
         end
         if (byte_index_ff == gse_pkg::LAST_INDEX) begin
            push          = 1'b1;
            push_job.kind = gse_pkg::JOB_TAIL;
            push_job.data = {req_data_byte, csum_new, 24'd0};
            group_hold_in = '0;
         end else if (byte_index_ff[1:0] == gse_pkg::GROUP_PHASE) begin
            push          = 1'b1;
            push_job.kind = gse_pkg::JOB_GROUP;
            push_job.data = {hold_base, req_data_byte, 8'd0};
            group_hold_in = '0;
         end else begin
            group_hold_in = {hold_base[15:0], req_data_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_first_ff   <= '0;
         id_second_ff  <= '0;
         byte_index_ff <= '0;
         group_hold_ff <= '0;
         checksum_ff   <= '0;
      end else begin
         id_first_ff   <= id_first_in;
         id_second_ff  <= id_second_in;
         byte_index_ff <= byte_index_in;
         group_hold_ff <= group_hold_in;
         checksum_ff   <= checksum_in;
      end
   end

endmodule

[src/gse_back.sv]
// Back end: walks each job's segments and emits one GCR byte per cycle while a job is queued and rsp_stall is low.
`timescale 1ns / 1ps

module gse_back (
   input  logic             clock,
   input  logic             reset,
   input  gse_pkg::job_type head_job,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_gcr_byte,
   output logic             rsp_run_last,
   output logic             rsp_sector_done
);

   logic [2:0] seg_ff, seg_in;
   logic [2:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;

   logic                  advance;
   logic                  produce;
   gse_pkg::seg_kind_type seg_kind;
   logic [31:0]           grp_word;
   logic [2:0]            last_seg;
   logic [39:0]           bits;
   logic                  job_end;

   assign rsp_valid       = valid_ff;
   assign rsp_gcr_byte    = byte_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_sector_done = done_ff;

   assign advance = !valid_ff || !rsp_stall;
   assign produce = advance && !queue_empty;

   always_comb begin
      seg_kind = gse_pkg::SEG_GRP;
      grp_word = head_job.data[39:8];
      last_seg = gse_pkg::GROUP_LAST_SEG;
      case (head_job.kind)
         gse_pkg::JOB_HEAD: begin
            last_seg = gse_pkg::HEAD_LAST_SEG;
            case (seg_ff)
               3'd0, 3'd5: seg_kind = gse_pkg::SEG_SYNC;
               3'd1: grp_word = {gse_pkg::HEADER_MARK, head_job.data[39:16]};
               3'd2: grp_word = {head_job.data[15:0], gse_pkg::HEADER_PAD,
                                 gse_pkg::HEADER_PAD};
               default: seg_kind = gse_pkg::SEG_ZERO;
            endcase
         end
         gse_pkg::JOB_TAIL: begin
            last_seg = gse_pkg::TAIL_LAST_SEG;
            case (seg_ff)
               3'd0: seg_kind = gse_pkg::SEG_GRP;
               3'd3: seg_kind = gse_pkg::SEG_GAP;
               default: seg_kind = gse_pkg::SEG_ZERO;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      case (seg_kind)
         gse_pkg::SEG_ZERO: bits = gse_pkg::ZERO_GROUP;
         gse_pkg::SEG_GRP:  bits = gse_pkg::gcr_group(grp_word);
         default:           bits = '0;
      endcase

      case (seg_kind)
         gse_pkg::SEG_SYNC: byte_in = gse_pkg::SYNC_BYTE;
         gse_pkg::SEG_GAP:  byte_in = gse_pkg::GAP_BYTE;
         default: begin
            case (sub_ff)
               3'd0:    byte_in = bits[39:32];
               3'd1:    byte_in = bits[31:24];
               3'd2:    byte_in = bits[23:16];
               3'd3:    byte_in = bits[15:8];
               default: byte_in = bits[7:0];
            endcase
         end
      endcase
   end

   always_comb begin
      job_end = (sub_ff == gse_pkg::LAST_SUB) && (seg_ff == last_seg);
      pop     = produce && job_end;
      seg_in  = seg_ff;
      sub_in  = sub_ff;
      if (produce) begin
         if (job_end) begin
            seg_in = '0;
            sub_in = '0;
         end else if (sub_ff == gse_pkg::LAST_SUB) begin
            seg_in = seg_ff + 3'd1;
            sub_in = '0;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end
      valid_in = advance ? produce : valid_ff;
      last_in  = job_end;
      done_in  = job_end && (head_job.kind == gse_pkg::JOB_TAIL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= '0;
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> last_ff)
      else $error("sector end without transaction end");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff <= gse_pkg::LAST_SUB && seg_ff <= gse_pkg::HEAD_LAST_SEG)
      else $error("segment position out of range");

   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> (seg_ff == 3'd0 && sub_ff == 3'd0))
      else $error("sequencer mid-job with no job queued");

endmodule

[test/gcr_sector_encoder_tb.sv]
// Testbench for gcr_sector_encoder: full sector images checked against a predictor.
`timescale 1ns / 1ps

module gcr_sector_encoder_tb;

   localparam int SECTOR_BYTES   = 256;
   localparam int TOTAL_ITEMS    = SECTOR_BYTES + 3;
   localparam int PHASE_ITEMS    = 86;
   localparam int DIRECTED_BYTES = 24;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   // 5-bit GCR code of nibble n sits at [5n +: 5]
   localparam logic [79:0] GCR_CODES = {
      5'h15, 5'h1e, 5'h1d, 5'h0d, 5'h1b, 5'h1a, 5'h19, 5'h09,
      5'h17, 5'h16, 5'h0f, 5'h0e, 5'h13, 5'h12, 5'h0b, 5'h0a
   };

   typedef struct packed {
      logic [7:0] gcr;
      logic       run_last;
      logic       sector_done;
   } image_byte_type;

   class sector_image_predictor;
      image_byte_type expected_image[$];
      logic [7:0]  id_first;
      logic [7:0]  id_second;
      logic [7:0]  byte_index;
      logic [23:0] group_hold;
      logic [7:0]  data_checksum;
      int          fail_count;

      function new();
         id_first = '0;
         id_second = '0;
         byte_index = '0;
         group_hold = '0;
         data_checksum = '0;
         fail_count = 0;
      endfunction

      function void push_byte(logic [7:0] value);
         image_byte_type entry;
         entry.gcr = value;
         entry.run_last = 1'b0;
         entry.sector_done = 1'b0;
         expected_image.push_back(entry);
      endfunction

      function void push_fill(logic [7:0] value, int count);
         for (int i = 0; i < count; i++) push_byte(value);
      endfunction

      function void push_group(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
         logic [31:0] word;
         logic [39:0] bits;
         logic [3:0]  nib;
         word = {a, b, c, d};
         bits = '0;
         for (int i = 0; i < 8; i++) begin
            nib = word[31 - 4*i -: 4];
            bits = {bits[34:0], GCR_CODES[5*nib +: 5]};
         end
         for (int j = 4; j >= 0; j--) push_byte(bits[8*j +: 8]);
      endfunction

      function void note_request(logic [7:0] trk, logic [7:0] sec, logic [7:0] data);
         int first_new;
         first_new = expected_image.size();
         if (byte_index == gse_pkg::FIRST_INDEX) begin
            push_fill(gse_pkg::SYNC_BYTE, 5);
            push_group(gse_pkg::HEADER_MARK, sec ^ trk ^ id_first ^ id_second, sec, trk);
            push_group(id_second, id_first, gse_pkg::HEADER_PAD, gse_pkg::HEADER_PAD);
            push_group(8'h00, 8'h00, 8'h00, 8'h00);
            push_group(8'h00, 8'h00, 8'h00, 8'h00);
            push_fill(gse_pkg::SYNC_BYTE, 5);
            data_checksum = '0;
            group_hold = {16'h0000, gse_pkg::BLOCK_MARK};
         end
         data_checksum = data_checksum ^ data;
         if (byte_index == gse_pkg::LAST_INDEX) begin
            push_group(data, data_checksum, 8'h00, 8'h00);
            push_group(8'h00, 8'h00, 8'h00, 8'h00);
            push_group(8'h00, 8'h00, 8'h00, 8'h00);
            push_fill(gse_pkg::GAP_BYTE, 5);
            group_hold = '0;
         end else if (byte_index[1:0] == gse_pkg::GROUP_PHASE) begin
            push_group(group_hold[23:16], group_hold[15:8], group_hold[7:0], data);
            group_hold = '0;
         end else begin
            group_hold = {group_hold[15:0], data};
         end
         if (expected_image.size() > first_new) begin
            expected_image[expected_image.size() - 1].run_last = 1'b1;
            if (byte_index == gse_pkg::LAST_INDEX)
               expected_image[expected_image.size() - 1].sector_done = 1'b1;
         end
         byte_index = byte_index + 8'd1;
      endfunction

      function void check_result(logic [7:0] gcr, logic run_last, logic sector_done);
         image_byte_type want;
         if (expected_image.size() == 0) begin
            $error("unexpected gcr_byte %02h with nothing pending", gcr);
            fail_count++;
            return;
         end
         want = expected_image.pop_front();
         if (gcr !== want.gcr) begin
            $error("gcr_byte: expected %02h, actual %02h", want.gcr, gcr);
            fail_count++;
         end
         if (run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
            fail_count++;
         end
         if (sector_done !== want.sector_done) begin
            $error("sector_done: expected %0b, actual %0b", want.sector_done, sector_done);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_track_number = '0;
   logic [7:0]  req_sector_number = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_gcr_byte;
   logic        rsp_run_last;
   logic        rsp_sector_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;

   sector_image_predictor image_check;

   gcr_sector_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_track_number(req_track_number),
      .req_sector_number(req_sector_number),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_gcr_byte(rsp_gcr_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_sector_done(rsp_sector_done),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         image_check.note_request(req_track_number, req_sector_number, req_data_byte);
      if (!reset && rsp_valid && !rsp_stall)
         image_check.check_result(rsp_gcr_byte, rsp_run_last, rsp_sector_done);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // all tasks start and end at a falling edge
   task automatic send_request(input logic [7:0] trk, input logic [7:0] sec,
                               input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_track_number <= trk;
      req_sector_number <= sec;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (image_check.expected_image.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      if (prdata !== value) begin
         $error("prdata: expected %08h, actual %08h", value, prdata);
         image_check.fail_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_disk_id(input logic [7:0] first, input logic [7:0] second);
      write_csr({gse_pkg::REG_ID_FIRST, 2'b00}, {24'h0, first});
      write_csr({gse_pkg::REG_ID_SECOND, 2'b00}, {24'h0, second});
      image_check.id_first = first;
      image_check.id_second = second;
   endtask

   initial begin
      logic [7:0] trk;
      logic [7:0] sec;
      logic [7:0] data;
      logic [3:0] nib;
      image_check = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_disk_id(8'hFF, 8'h00);

      for (int k = 0; k < TOTAL_ITEMS; k++) begin
         if (k < PHASE_ITEMS) begin
            sender_idle_pct = 12;
            rsp_stall_pct = 61;
         end else if (k < 2 * PHASE_ITEMS) begin
            sender_idle_pct = 61;
            rsp_stall_pct = 12;
         end else begin
            sender_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         trk = 8'($urandom);
         sec = 8'($urandom);
         data = 8'($urandom);
         // out-of-range header values are encoded as given
         if (k == 0) begin
            trk = 8'hFF;
            sec = 8'hFF;
         end
         // second sector after the wrap, with fresh disk IDs
         if (k == SECTOR_BYTES) begin
            trk = 8'($urandom_range(42, 1));
            sec = 8'($urandom_range(20, 0));
            drain_block();
            set_disk_id(8'($urandom), 8'($urandom));
         end
         if (k < DIRECTED_BYTES) begin
            nib = 4'(k - 2);
            if (k == 0) data = 8'h00;
            else if (k == 1) data = 8'hFF;
            else if (k < 18) data = {nib, ~nib};
         end
         send_request(trk, sec, data);
         // ID change mid-sector must not touch this sector's header
         if (k == 50) begin
            drain_block();
            set_disk_id(8'($urandom), 8'($urandom));
         end
      end

      drain_block();
      if (image_check.fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
